[src/ldf_pkg.sv]
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ldf_pkg;

    // Header layout: start byte, function code, 16-bit big-endian total length
    localparam int HDR_BYTES = 4;
    localparam int HDR_IDX_W = $clog2(HDR_BYTES);

    // Function codes that are passed on
    localparam logic [7:0] CODE_MEASURE = 8'hA1;
    localparam logic [7:0] CODE_SHIELD  = 8'hA7;

    // Frame kinds held while inside a frame
    localparam logic [1:0] KIND_MEASURE = 2'd0;
    localparam logic [1:0] KIND_SHIELD  = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    // Queue between front and back
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // One queued item: a single payload byte or a four-byte header burst
    typedef struct packed {
        logic [HDR_BYTES-1:0][7:0] bytes;  // bytes[0] goes out first
        logic                      kind;
        logic                      burst;
        logic                      last;   // frame ends on the final byte
    } q_entry_t;

    // Queue status seen by the front and the top level
    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QCOUNT_W-1:0] count;
    } q_stat_t;

endpackage : ldf_pkg

`default_nettype wire

[src/ldf_if.sv]
// ----------------------------------------------------------------------------
// ldf_if
// Handshake channels of the deframer: input bytes, results, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface ldf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface : ldf_in_if

interface ldf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_kind;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       last_of_run;

    modport source (output valid, output out_byte, output frame_kind,
                    output first_of_frame, output last_of_frame,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input frame_kind,
                    input first_of_frame, input last_of_frame,
                    input last_of_run, output ready);
endinterface : ldf_out_if

interface ldf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_header;

    modport source (output valid, output frame_header, input ready);
    modport sink   (input valid, input frame_header, output ready);
endinterface : ldf_cfg_if

`default_nettype wire

[src/ldf_front.sv]
// ----------------------------------------------------------------------------
// ldf_front
// Hunts for the header, collects the header window, checks the length and
// tracks the frame; pushes result items for the back end into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ldf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ldf_in_if.sink                stream,
    input  wire logic [7:0]       frame_header,
    input  wire ldf_pkg::q_stat_t q_stat,
    output      logic             push,
    output      ldf_pkg::q_entry_t push_entry
);

    logic [7:0]                     win0_reg, win1_reg, win2_reg;
    logic [7:0]                     win0_next, win1_next, win2_next;
    logic [ldf_pkg::HDR_IDX_W-1:0]  fill_reg, fill_next;
    logic                           in_payload_reg, in_payload_next;
    logic [15:0]                    bytes_left_reg, bytes_left_next;
    logic [1:0]                     kind_reg, kind_next;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] len;
    logic [1:0]  hdr_kind;

    assign stream.ready = !q_stat.full;
    assign accept       = stream.valid && !q_stat.full;
    assign b            = stream.in_byte;
    assign len          = {win2_reg, b};

    // Classify the function code
    always_comb
    begin
        case (win1_reg)
            ldf_pkg::CODE_MEASURE: hdr_kind = ldf_pkg::KIND_MEASURE;
            ldf_pkg::CODE_SHIELD:  hdr_kind = ldf_pkg::KIND_SHIELD;
            default:               hdr_kind = ldf_pkg::KIND_DISCARD;
        endcase
    end

    // Advance the parse on each accepted byte
    always_comb
    begin
        win0_next       = win0_reg;
        win1_next       = win1_reg;
        win2_next       = win2_reg;
        fill_next       = fill_reg;
        in_payload_next = in_payload_reg;
        bytes_left_next = bytes_left_reg;
        kind_next       = kind_reg;
        push            = 1'b0;
        push_entry      = '0;

        if (accept) begin
            if (in_payload_reg) begin
                // Pass one payload byte, drop it for discarded frames
                bytes_left_next = bytes_left_reg - 16'd1;
                push_entry.bytes[0] = b;
                push_entry.kind     = kind_reg[0];
                push_entry.burst    = 1'b0;
                push_entry.last     = (bytes_left_reg == 16'd1);
                push                = (kind_reg != ldf_pkg::KIND_DISCARD);
                if (bytes_left_reg == 16'd1) begin
                    in_payload_next = 1'b0;
                end
            end else begin
                case (fill_reg)
                    2'd0:
                    begin
                        if (b == frame_header) begin
                            win0_next = b;
                            fill_next = 2'd1;
                        end
                    end
                    2'd1:
                    begin
                        win1_next = b;
                        fill_next = 2'd2;
                    end
                    2'd2:
                    begin
                        win2_next = b;
                        fill_next = 2'd3;
                    end
                    default:
                    begin
                        if (len < 16'(ldf_pkg::HDR_BYTES)) begin
                            // False header: drop its start and rescan the rest
                            if (win1_reg == frame_header) begin
                                win0_next = win1_reg;
                                win1_next = win2_reg;
                                win2_next = b;
                                fill_next = 2'd3;
                            end else if (win2_reg == frame_header) begin
                                win0_next = win2_reg;
                                win1_next = b;
                                fill_next = 2'd2;
                            end else if (b == frame_header) begin
                                win0_next = b;
                                fill_next = 2'd1;
                            end else begin
                                fill_next = 2'd0;
                            end
                        end else begin
                            // Valid header: start the frame, queue the burst
                            kind_next       = hdr_kind;
                            bytes_left_next = len - 16'(ldf_pkg::HDR_BYTES);
                            fill_next       = 2'd0;
                            in_payload_next = (len != 16'(ldf_pkg::HDR_BYTES));
                            push_entry.bytes[0] = win0_reg;
                            push_entry.bytes[1] = win1_reg;
                            push_entry.bytes[2] = win2_reg;
                            push_entry.bytes[3] = b;
                            push_entry.kind     = hdr_kind[0];
                            push_entry.burst    = 1'b1;
                            push_entry.last     = (len == 16'(ldf_pkg::HDR_BYTES));
                            push                = (hdr_kind != ldf_pkg::KIND_DISCARD);
                        end
                    end
                endcase
            end
        end
    end

    // Hold parse control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg       <= '0;
            in_payload_reg <= 1'b0;
            bytes_left_reg <= '0;
            kind_reg       <= ldf_pkg::KIND_MEASURE;
        end else begin
            fill_reg       <= fill_next;
            in_payload_reg <= in_payload_next;
            bytes_left_reg <= bytes_left_next;
            kind_reg       <= kind_next;
        end
    end

    // Hold header window bytes
    always_ff @(posedge clk)
    begin
        win0_reg <= win0_next;
        win1_reg <= win1_next;
        win2_reg <= win2_next;
    end

endmodule : ldf_front

`default_nettype wire

[src/ldf_queue.sv]
// ----------------------------------------------------------------------------
// ldf_queue
// Small FIFO of result items between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ldf_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ldf_pkg::q_entry_t push_entry,
    input  wire logic              pop,
    output      ldf_pkg::q_entry_t head,
    output      ldf_pkg::q_stat_t  stat
);

    ldf_pkg::q_entry_t mem_reg [ldf_pkg::QDEPTH];

    logic [ldf_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ldf_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ldf_pkg::QCOUNT_W-1:0] count_reg, count_next;
    logic                         do_push, do_pop;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == ldf_pkg::QCOUNT_W'(ldf_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule : ldf_queue

`default_nettype wire

[src/ldf_back.sv]
// ----------------------------------------------------------------------------
// ldf_back
// Takes queued items and sends them out one byte per result, unrolling
// header bursts into four results with first and last marks.
// ----------------------------------------------------------------------------
`default_nettype none

module ldf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ldf_pkg::q_entry_t head,
    input  wire ldf_pkg::q_stat_t  q_stat,
    output      logic              pop,
    ldf_out_if.source              result
);

    localparam logic [ldf_pkg::HDR_IDX_W-1:0] LAST_SUB =
        ldf_pkg::HDR_IDX_W'(ldf_pkg::HDR_BYTES - 1);

    logic [ldf_pkg::HDR_IDX_W-1:0] sub_reg, sub_next;
    logic                          run_end;
    logic                          send;

    assign run_end = !head.burst || (sub_reg == LAST_SUB);
    assign send    = result.valid && result.ready;
    assign pop     = send && run_end;

    // Drive the result fields from the queue head
    assign result.valid          = !q_stat.empty;
    assign result.out_byte       = head.burst ? head.bytes[sub_reg] : head.bytes[0];
    assign result.frame_kind     = head.kind;
    assign result.first_of_frame = head.burst && (sub_reg == '0);
    assign result.last_of_frame  = head.last && run_end;
    assign result.last_of_run    = run_end;

    // Step through a burst, restart on each new item
    always_comb
    begin
        sub_next = sub_reg;
        if (send) begin
            sub_next = run_end ? '0 : sub_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sub_reg <= '0;
        end else begin
            sub_reg <= sub_next;
        end
    end

endmodule : ldf_back

`default_nettype wire

[src/length_prefixed_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_unit
// Cuts header/length framed packets out of a byte stream.
//
// Channels: stream takes one received byte per item. result gives one byte
// of a passed frame per item with its kind, first/last of frame marks and a
// last_of_run mark on the final result caused by one input byte. cfg writes
// the header byte value (reset value 1); write it only while the block is
// idle, it is always ready.
// Each result is registered in the queue before it appears on result.
// Throughput: one input byte per cycle. A valid header with code 0xA1 or
// 0xA7 produces a burst of four results on its fourth byte; the back end
// sends one result per cycle while result.ready is high, and the
// four-entry queue between the parser and the sender absorbs the burst
// while input keeps flowing. Input stalls only when that queue is full.
// Reset: the hunt restarts with an empty header window and an empty queue.
// A stalled receiver holds the current result; the parser keeps taking
// bytes until the queue fills, then drops stream.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_deframer_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    ldf_in_if.sink    stream,
    ldf_out_if.source result,
    ldf_cfg_if.sink   cfg
);

    logic [7:0]        frame_header_reg;
    logic              push;
    logic              pop;
    ldf_pkg::q_entry_t push_entry;
    ldf_pkg::q_entry_t head;
    ldf_pkg::q_stat_t  q_stat;

    // Hold the header byte value
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_header_reg <= 8'd1;
        end else if (cfg.valid) begin
            frame_header_reg <= cfg.frame_header;
        end
    end

    ldf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream       (stream),
        .frame_header (frame_header_reg),
        .q_stat       (q_stat),
        .push         (push),
        .push_entry   (push_entry)
    );

    ldf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    ldf_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .result (result)
    );

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= ldf_pkg::QCOUNT_W'(ldf_pkg::QDEPTH))
        else $error("queue count above depth");

    a_first_not_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.first_of_frame |-> !result.last_of_run)
        else $error("header burst ends on its first byte");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.first_of_frame |-> !result.last_of_frame)
        else $error("frame ends on its header byte");

    a_burst_steps: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && result.first_of_frame
        |=> result.valid && !result.first_of_frame)
        else $error("header burst broken after its first byte");

endmodule : length_prefixed_frame_deframer_unit

`default_nettype wire
